### src/srk_pkg.sv
// shared constants and helper functions for the symmetric rank-1 update unit
package srk_pkg;

    // field widths fixed by the item format
    localparam int IDX_W   = 13;
    localparam int DIM_W   = 14;
    localparam int FP_W    = 32;
    localparam int CFG_A_W = 2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DIM     = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_ALPHA   = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_UPPER   = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_REVERSE = 2'd3;

    // item kinds carried in tuser
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // binary32 constants
    localparam logic [FP_W-1:0] FP_QNAN    = 32'h7FC0_0000;
    localparam logic [7:0]      FP_EXP_MAX = 8'hFF;

    // leading zero count of a 48-bit product
    function automatic logic [5:0] f_lzc48(input logic [47:0] v);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

    // leading zero count of a 27-bit sum
    function automatic logic [4:0] f_lzc27(input logic [26:0] v);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

endpackage

### src/srk_xmem.sv
// vector store: one write port, two registered read ports
module srk_xmem
    import srk_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [FP_W-1:0] i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr0,
    input  logic [AW-1:0]   i_rd_addr1,
    output logic [FP_W-1:0] o_rd_data0,
    output logic [FP_W-1:0] o_rd_data1
);

    logic [FP_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two read ports, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data0 <= r_mem[i_rd_addr0];
            o_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

endmodule

### src/srk_fmul.sv
// two-stage binary32 multiplier, round to nearest even
module srk_fmul
    import srk_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en1,
    input  logic            i_en2,
    input  logic [FP_W-1:0] i_a,
    input  logic [FP_W-1:0] i_b,
    output logic [FP_W-1:0] o_p
);

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]  a_e, b_e;
    logic [23:0] a_m, b_m;

    logic [47:0] r_prod;
    logic [8:0]  r_esum;
    logic        r_sign, r_nan, r_inf, r_zero;

    logic [5:0]        lz;
    logic signed [9:0] be;
    logic signed [9:0] lsh;
    logic [5:0]        rs;
    logic [95:0]       rt;
    logic [47:0]       q;
    logic              stk;
    logic              up;
    logic [7:0]        exp_f;
    logic [30:0]       mag;
    logic [FP_W-1:0]   n_p;

    // operand decode
    always_comb begin
        a_nan  = (i_a[30:23] == FP_EXP_MAX) && (i_a[22:0] != '0);
        b_nan  = (i_b[30:23] == FP_EXP_MAX) && (i_b[22:0] != '0);
        a_inf  = (i_a[30:23] == FP_EXP_MAX) && (i_a[22:0] == '0);
        b_inf  = (i_b[30:23] == FP_EXP_MAX) && (i_b[22:0] == '0);
        a_zero = (i_a[30:0] == '0);
        b_zero = (i_b[30:0] == '0);
        a_e    = (i_a[30:23] == '0) ? 8'd1 : i_a[30:23];
        b_e    = (i_b[30:23] == '0) ? 8'd1 : i_b[30:23];
        a_m    = {(i_a[30:23] != '0), i_a[22:0]};
        b_m    = {(i_b[30:23] != '0), i_b[22:0]};
    end

    // stage 1: mantissa product and exponent sum
    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_prod <= a_m * b_m;
            r_esum <= {1'b0, a_e} + {1'b0, b_e};
            r_sign <= i_a[31] ^ i_b[31];
            r_nan  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
            r_inf  <= a_inf || b_inf;
            r_zero <= a_zero || b_zero;
        end
    end

    // stage 2: normalize, denormalize and round
    always_comb begin
        lz  = f_lzc48(r_prod);
        be  = $signed({1'b0, r_esum}) - 10'sd126 - $signed({4'b0, lz});
        lsh = (be >= 10'sd1) ? $signed({4'b0, lz}) : ($signed({1'b0, r_esum}) - 10'sd127);
        rs  = (lsh < -10'sd48) ? 6'd48 : 6'(-lsh);
        rt  = {r_prod, 48'b0} >> rs;
        if (lsh >= 10'sd0) begin
            q   = r_prod << lsh[5:0];
            stk = 1'b0;
        end else begin
            q   = rt[95:48];
            stk = |rt[47:0];
        end
        up    = q[23] && ((|q[22:0]) || stk || q[24]);
        exp_f = (be >= 10'sd1) ? be[7:0] : 8'd0;
        mag   = {exp_f, q[46:24]} + {30'b0, up};
        if (r_nan) begin
            n_p = FP_QNAN;
        end else if (r_inf || (be >= 10'sd255)) begin
            n_p = {r_sign, FP_EXP_MAX, 23'b0};
        end else if (r_zero) begin
            n_p = {r_sign, 31'b0};
        end else begin
            n_p = {r_sign, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            o_p <= n_p;
        end
    end

endmodule

### src/srk_fadd.sv
// two-stage binary32 adder, round to nearest even
module srk_fadd
    import srk_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en1,
    input  logic            i_en2,
    input  logic [FP_W-1:0] i_a,
    input  logic [FP_W-1:0] i_b,
    output logic [FP_W-1:0] o_s
);

    logic            swap, sub;
    logic [FP_W-1:0] x, y;
    logic            x_nan, y_nan, x_inf, y_inf;
    logic [7:0]      ex, ey, d;
    logic [4:0]      ds;
    logic [26:0]     x27, y27, yal;
    logic [53:0]     yt;
    logic [27:0]     sum;

    logic [27:0] r_sum;
    logic [7:0]  r_e;
    logic        r_sign, r_nan, r_inf, r_inf_sign;

    logic [4:0]  lz;
    logic [7:0]  lim, ls;
    logic [26:0] nrm;
    logic [8:0]  ne;
    logic        up;
    logic [7:0]  exp_f;
    logic [30:0] mag;
    logic [FP_W-1:0] n_s;

    // stage 1: order by magnitude, align, add or subtract
    always_comb begin
        swap  = i_b[30:0] > i_a[30:0];
        x     = swap ? i_b : i_a;
        y     = swap ? i_a : i_b;
        sub   = x[31] ^ y[31];
        x_nan = (x[30:23] == FP_EXP_MAX) && (x[22:0] != '0);
        y_nan = (y[30:23] == FP_EXP_MAX) && (y[22:0] != '0);
        x_inf = (x[30:23] == FP_EXP_MAX) && (x[22:0] == '0);
        y_inf = (y[30:23] == FP_EXP_MAX) && (y[22:0] == '0);
        ex    = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == '0) ? 8'd1 : y[30:23];
        d     = ex - ey;
        ds    = (d > 8'd27) ? 5'd27 : d[4:0];
        x27   = {(x[30:23] != '0), x[22:0], 3'b0};
        y27   = {(y[30:23] != '0), y[22:0], 3'b0};
        yt    = {y27, 27'b0} >> ds;
        yal   = {yt[53:28], yt[27] | (|yt[26:0])};
        sum   = sub ? ({1'b0, x27} - {1'b0, yal}) : ({1'b0, x27} + {1'b0, yal});
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_sum      <= sum;
            r_e        <= ex;
            r_sign     <= (sub && (sum == '0)) ? 1'b0 : x[31];
            r_nan      <= x_nan || y_nan || (x_inf && y_inf && sub);
            r_inf      <= x_inf || y_inf;
            r_inf_sign <= x[31];
        end
    end

    // stage 2: normalize and round
    always_comb begin
        lz  = f_lzc27(r_sum[26:0]);
        lim = r_e - 8'd1;
        ls  = ({3'b0, lz} < lim) ? {3'b0, lz} : lim;
        if (r_sum[27]) begin
            nrm = {r_sum[27:2], r_sum[1] | r_sum[0]};
            ne  = {1'b0, r_e} + 9'd1;
        end else begin
            nrm = r_sum[26:0] << ls;
            ne  = {1'b0, r_e} - {1'b0, ls};
        end
        up    = nrm[2] && ((|nrm[1:0]) || nrm[3]);
        exp_f = nrm[26] ? ne[7:0] : 8'd0;
        mag   = {exp_f, nrm[25:3]} + {30'b0, up};
        if (r_nan) begin
            n_s = FP_QNAN;
        end else if (r_inf) begin
            n_s = {r_inf_sign, FP_EXP_MAX, 23'b0};
        end else if (ne >= 9'd255) begin
            n_s = {r_sign, FP_EXP_MAX, 23'b0};
        end else begin
            n_s = {r_sign, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            o_s <= n_s;
        end
    end

endmodule

### src/symmetric_rank1_update_unit.sv
// symmetric rank-1 update unit: vector store, two multipliers and an adder in one pipeline
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind; tdata position,row,col,value
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser touched; tdata row_out,col_out,result
// cfg       in   i_cfg_we                       i_cfg_addr index, i_cfg_wdata value
//
// eight register stages: input, vector read, alpha*x[row] (2), times x[col] (2), add (2)
// one item per cycle unless a stall has filled the pipeline; an update item gives its result from the last stage
// load items write the store in the vector read stage and leave no result
// a stall only holds stages that are full; empty stages keep filling
// reset clears the valid bits and sets the configuration to its defaults; the store is not cleared
module symmetric_rank1_update_unit
    import srk_pkg::*;
#(
    parameter int MAX_DIM = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_A_W-1:0]    i_cfg_addr,
    input  logic [FP_W-1:0]       i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic                  s_axis_tuser,   // kind
    input  logic [71:0]           s_axis_tdata,   // position, row, col, value, pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tuser,   // touched
    output logic [63:0]           m_axis_tdata    // row_out, col_out, result, pad
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NB = $clog2(MAX_DIM + 1);
    localparam int NW = (NB > DIM_W) ? NB : DIM_W;
    localparam int NS = 8;

    // configuration
    logic [DIM_W-1:0] r_dim;
    logic [FP_W-1:0]  r_alpha;
    logic             r_upper;
    logic             r_reverse;

    // pipeline control
    logic             r_v [NS];
    logic [NS-1:0]    en;

    // payload through the stages
    logic             r_kind;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_row [NS];
    logic [IDX_W-1:0] r_col [NS];
    logic [FP_W-1:0]  r_a   [NS];
    logic             r_ins [NS];
    logic [FP_W-1:0]  r_xc2, r_xc3;

    logic [NW-1:0]    n_eff;
    logic [NW-1:0]    pos_w, row_w, col_w, widx;
    logic             n_ins;
    logic             wr_en;
    logic [FP_W-1:0]  xr, xc, ax, prod, sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim     <= 14'd1;
            r_alpha   <= 32'h3F80_0000;
            r_upper   <= 1'b1;
            r_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIM:     r_dim     <= i_cfg_wdata[DIM_W-1:0];
                CFG_ALPHA:   r_alpha   <= i_cfg_wdata;
                CFG_UPPER:   r_upper   <= i_cfg_wdata[0];
                CFG_REVERSE: r_reverse <= i_cfg_wdata[0];
                default:     r_upper   <= r_upper;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NS-1] = !r_v[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    // valid bits; load items drop out after the store stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0] && (r_kind == KIND_UPDATE);
            end
            for (int k = 2; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_kind   <= s_axis_tuser;
            r_pos    <= s_axis_tdata[12:0];
            r_row[0] <= s_axis_tdata[25:13];
            r_col[0] <= s_axis_tdata[38:26];
            r_a[0]   <= s_axis_tdata[70:39];
        end
    end

    // range checks and store index
    always_comb begin
        n_eff = (NW'(r_dim) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(r_dim);
        pos_w = NW'(r_pos);
        row_w = NW'(r_row[0]);
        col_w = NW'(r_col[0]);
        widx  = r_reverse ? (n_eff - NW'(1) - pos_w) : pos_w;
        n_ins = (row_w < n_eff) && (col_w < n_eff) &&
                (r_upper ? (col_w >= row_w) : (col_w <= row_w));
        wr_en = r_v[0] && (r_kind == KIND_LOAD) && (pos_w < n_eff) && en[1];
    end

    srk_xmem #(
        .DEPTH (MAX_DIM),
        .AW    (AW)
    ) u_xmem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (AW'(widx)),
        .i_wr_data  (r_a[0]),
        .i_rd_en    (en[1]),
        .i_rd_addr0 (AW'(r_row[0])),
        .i_rd_addr1 (AW'(r_col[0])),
        .o_rd_data0 (xr),
        .o_rd_data1 (xc)
    );

    // side fields travel with the item
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ins[1] <= n_ins;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_row[k] <= r_row[k-1];
                r_col[k] <= r_col[k-1];
                r_a[k]   <= r_a[k-1];
            end
        end
        for (int k = 2; k < NS; k++) begin
            if (en[k]) begin
                r_ins[k] <= r_ins[k-1];
            end
        end
        if (en[2]) begin
            r_xc2 <= xc;
        end
        if (en[3]) begin
            r_xc3 <= r_xc2;
        end
    end

    // alpha * x[row]
    srk_fmul u_fmul_ax (
        .i_clk (i_clk),
        .i_en1 (en[2]),
        .i_en2 (en[3]),
        .i_a   (r_alpha),
        .i_b   (xr),
        .o_p   (ax)
    );

    // times x[col]
    srk_fmul u_fmul_px (
        .i_clk (i_clk),
        .i_en1 (en[4]),
        .i_en2 (en[5]),
        .i_a   (ax),
        .i_b   (r_xc3),
        .o_p   (prod)
    );

    // a + product
    srk_fadd u_fadd (
        .i_clk (i_clk),
        .i_en1 (en[6]),
        .i_en2 (en[7]),
        .i_a   (r_a[5]),
        .i_b   (prod),
        .o_s   (sum)
    );

    // output
    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tuser  = r_ins[NS-1];
    assign m_axis_tdata  = {6'b0, (r_ins[NS-1] ? sum : r_a[NS-1]),
                            r_col[NS-1], r_row[NS-1]};

    // a full pipeline with a stalled output is the only reason to refuse an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused while pipeline can move");

    // load items never reach the arithmetic stages
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && (r_kind == KIND_LOAD) && en[1]) |=> !r_v[1])
        else $error("load item entered arithmetic stages");

    // untouched elements pass through bit for bit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[57:26] == r_a[NS-1]))
        else $error("untouched element altered");

    // updated elements never carry a non-canonical nan
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && (m_axis_tdata[56:49] == FP_EXP_MAX) &&
         (m_axis_tdata[48:26] != '0)) |-> (m_axis_tdata[57:26] == FP_QNAN))
        else $error("non-canonical nan on updated element");

endmodule

### verif/tb_symmetric_rank1_update_unit.sv
// testbench for the symmetric rank-1 update unit: directed and random items checked on a predictor
`timescale 1ns / 100ps

module tb_symmetric_rank1_update_unit;
    import srk_pkg::*;

    localparam int STORE_DEPTH = 8192;
    localparam int PIPE_DEPTH  = 8;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [FP_W-1:0]  elem;
        logic             touched;
    } t_elem_out;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_A_W-1:0]  i_cfg_addr;
    logic [FP_W-1:0]     i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic                s_axis_tuser;   // kind
    logic [71:0]         s_axis_tdata;   // position, row, col, value, pad
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                m_axis_tuser;   // touched
    logic [63:0]         m_axis_tdata;   // row_out, col_out, result, pad

    // predictor state: configuration and vector copy
    logic [DIM_W-1:0]    cur_dim;
    logic [FP_W-1:0]     cur_alpha;
    logic                cur_upper;
    logic                cur_reverse;
    logic [FP_W-1:0]     x_copy [STORE_DEPTH];
    bit                  x_written [STORE_DEPTH];
    int                  phase_idx [$];

    t_elem_out           elem_expected [$];
    int                  n_errors;
    int                  gap_left;
    bit                  hold_off;

    symmetric_rank1_update_unit i_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // binary32 bits to real, exact
    function automatic real fp_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF)
            r = $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
        else if (b[30:23] == 8'd0)
            r = (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
        else
            r = $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
        if (b[30:0] == 31'd0)
            r = $bitstoreal({b[31], 63'd0});
        return r;
    endfunction

    // round a real to binary32, nearest even, with subnormals and overflow
    function automatic logic [31:0] real_to_fp(input real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'd0};
        if (d[62:0] == 63'd0)
            return {d[63], 31'd0};
        e   = int'(d[62:52]) - 1023;
        sig = {11'd1, d[51:0]};
        sh  = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            sh = 60;
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (e < -126)
            return {d[63], kept[30:0]};
        if (kept[24]) begin
            kept = kept >> 1;
            e = e + 1;
        end
        if (e + 127 >= 255)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], 8'(e + 127), kept[22:0]};
    endfunction

    function automatic int eff_n();
        return (cur_dim > STORE_DEPTH) ? STORE_DEPTH : int'(cur_dim);
    endfunction

    // predict one accepted item: store write or expected element
    task automatic predict_item(input logic kind, input int pos, input int row,
                                input int col, input logic [31:0] val);
        t_elem_out e;
        int        n;
        bit        in_tri;
        logic [31:0] ax;
        logic [31:0] prod;
        n = eff_n();
        if (kind == KIND_LOAD) begin
            if (pos < n) begin
                x_copy[cur_reverse ? n - 1 - pos : pos] = val;
                x_written[cur_reverse ? n - 1 - pos : pos] = 1'b1;
            end
            return;
        end
        in_tri = row < n && col < n && (cur_upper ? col >= row : col <= row);
        e.row = row[12:0];
        e.col = col[12:0];
        e.elem = val;
        e.touched = in_tri;
        if (in_tri) begin
            if (!x_written[row] || !x_written[col])
                $display("%0t: stimulus error, unwritten vector entry read", $realtime);
            ax   = real_to_fp(fp_to_real(cur_alpha) * fp_to_real(x_copy[row]));
            prod = real_to_fp(fp_to_real(ax) * fp_to_real(x_copy[col]));
            e.elem = real_to_fp(fp_to_real(val) + fp_to_real(prod));
            if (e.elem[30:23] == FP_EXP_MAX && e.elem[22:0] != 0)
                e.elem = FP_QNAN;
        end
        elem_expected.push_back(e);
    endtask

    // send one item, with bursty gaps before it
    task automatic send_item(input logic kind, input int pos, input int row,
                             input int col, input logic [31:0] val);
        if (gap_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
            gap_left = $urandom_range(1, 20);
        end
        gap_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, val, col[12:0], row[12:0], pos[12:0]};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        predict_item(kind, pos, row, col, val);
    endtask

    // wait for every expected element, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        gap_left = 0;
        while (elem_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable after the last one
    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DIM:     cur_dim     = val[DIM_W-1:0];
            CFG_ALPHA:   cur_alpha   = val;
            CFG_UPPER:   cur_upper   = val[0];
            CFG_REVERSE: cur_reverse = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int dim, input logic [31:0] alpha,
                              input bit up, input bit rev);
        drain();
        write_reg(CFG_DIM, 32'(dim));
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_UPPER, 32'(up));
        write_reg(CFG_REVERSE, 32'(rev));
        i_cfg_we <= 1'b0;
    endtask

    // random binary32 with a bias toward specials and usable magnitudes
    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:0] = 31'd0;
            1: v[30:0] = {8'hFF, 23'd0};
            2: v[30:23] = 8'hFF;
            3: v[30:23] = 8'd0;
            4: v[30:23] = 8'($urandom_range(250, 254));
            5: ;
            default: v[30:23] = 8'($urandom_range(115, 139));
        endcase
        return v;
    endfunction

    // load a logical entry through its memory position
    task automatic load_logical(input int idx, input logic [31:0] val);
        int n;
        n = eff_n();
        send_item(KIND_LOAD, cur_reverse ? n - 1 - idx : idx, $urandom, $urandom, val);
        phase_idx.push_back(idx);
    endtask

    // update inside the triangle on loaded entries
    task automatic update_inside(input logic [31:0] val);
        int r;
        int c;
        int t;
        r = phase_idx[$urandom_range(0, phase_idx.size() - 1)];
        c = phase_idx[$urandom_range(0, phase_idx.size() - 1)];
        if (cur_upper ? c < r : c > r) begin
            t = r;
            r = c;
            c = t;
        end
        send_item(KIND_UPDATE, $urandom, r, c, val);
    endtask

    // update that stays outside the triangle or range
    task automatic update_outside();
        int n;
        int r;
        int c;
        int t;
        n = eff_n();
        r = $urandom_range(0, 8191);
        c = $urandom_range(0, 8191);
        // a diagonal element moves off the diagonal or beyond the range
        if (r < n && c < n && r == c) begin
            if (n < STORE_DEPTH)
                c = n;
            else
                c = (r == 0) ? 1 : r - 1;
        end
        // an element inside the triangle is mirrored to the other side
        if (r < n && c < n && (cur_upper ? c >= r : c <= r)) begin
            t = r;
            r = c;
            c = t;
        end
        send_item(KIND_UPDATE, $urandom, r, c, rand_fp());
    endtask

    // extremes, every kind, and the listed corner cases
    task automatic test_directed();
        set_config(4, 32'h3F80_0000, 1'b1, 1'b0);
        phase_idx.delete();
        load_logical(0, 32'h4000_0000);
        load_logical(1, 32'hBF80_0000);
        load_logical(2, 32'h7F7F_FFFF);
        load_logical(3, 32'h0000_0001);
        send_item(KIND_LOAD, 4, 0, 0, 32'hFFFF_FFFF);          // load out of range
        send_item(KIND_LOAD, 8191, 0, 0, 32'h1234_5678);
        send_item(KIND_UPDATE, 0, 0, 0, 32'h3F80_0000);
        send_item(KIND_UPDATE, 0, 0, 3, 32'h8000_0000);
        send_item(KIND_UPDATE, 0, 2, 2, 32'h7F7F_FFFF);         // overflow to infinity
        send_item(KIND_UPDATE, 0, 3, 3, 32'h8000_0000);         // product underflows to zero
        send_item(KIND_UPDATE, 0, 1, 0, 32'h4040_0000);         // below diagonal passes
        send_item(KIND_UPDATE, 0, 4, 4, 32'h7FA0_0001);         // out of range keeps nan bits
        send_item(KIND_UPDATE, 8191, 8191, 8191, 32'hFFFF_FFFF);
        send_item(KIND_UPDATE, 0, 2, 2, 32'hFF80_0000);         // inf plus -inf gives nan
        send_item(KIND_UPDATE, 0, 0, 1, 32'h7FC1_2345);
        set_config(4, 32'hFF80_0000, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 0, 1, 0, 32'h0000_0000);
        send_item(KIND_LOAD, 0, 0, 0, 32'h0000_0000);           // reverse: logical 3
        send_item(KIND_UPDATE, 0, 3, 3, 32'h3F80_0000);         // inf times zero
        send_item(KIND_UPDATE, 0, 0, 1, 32'h3F80_0000);
        set_config(0, 32'h3F80_0000, 1'b1, 1'b0);               // zero dim
        send_item(KIND_LOAD, 0, 0, 0, 32'h4000_0000);
        send_item(KIND_UPDATE, 0, 0, 0, 32'h4000_0000);
    endtask

    // one random phase under the given settings
    task automatic test_random_phase(input int dim, input logic [31:0] alpha, input bit up,
                                     input bit rev, input int items);
        int n;
        int sel;
        set_config(dim, alpha, up, rev);
        n = eff_n();
        phase_idx.delete();
        if (n > 0) begin
            load_logical(0, rand_fp());
            load_logical(n - 1, rand_fp());
        end
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(0, 99);
            if (n == 0 || sel < 8)
                update_outside();
            else if (sel < 30)
                load_logical($urandom_range(0, n - 1), rand_fp());
            else if (sel < 34 && n < STORE_DEPTH)
                send_item(KIND_LOAD, $urandom_range(n, 8191), $urandom, $urandom, $urandom);
            else
                update_inside(rand_fp());
        end
    endtask

    // block fills while the output is held off
    task automatic test_backpressure();
        set_config(64, 32'h4000_0000, 1'b1, 1'b0);
        phase_idx.delete();
        for (int i = 0; i < 64; i++) load_logical(i, rand_fp());
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++) update_inside(rand_fp());
        join
    endtask

    // output stall pattern
    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (((int'($realtime) / 1000) % 40) < 12)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_elem_out e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (elem_expected.size() == 0) begin
                $display("%0t: unexpected element row %0d col %0d result %h", $realtime,
                         m_axis_tdata[12:0], m_axis_tdata[25:13], m_axis_tdata[57:26]);
                n_errors++;
            end else begin
                e = elem_expected.pop_front();
                if (m_axis_tdata[12:0] !== e.row) begin
                    $display("%0t: row_out expected %0d actual %0d", $realtime, e.row,
                             m_axis_tdata[12:0]);
                    n_errors++;
                end
                if (m_axis_tdata[25:13] !== e.col) begin
                    $display("%0t: col_out expected %0d actual %0d", $realtime, e.col,
                             m_axis_tdata[25:13]);
                    n_errors++;
                end
                if (m_axis_tdata[57:26] !== e.elem) begin
                    $display("%0t: result expected %h actual %h (row %0d col %0d)",
                             $realtime, e.elem, m_axis_tdata[57:26], e.row, e.col);
                    n_errors++;
                end
                if (m_axis_tuser !== e.touched) begin
                    $display("%0t: touched expected %b actual %b", $realtime, e.touched,
                             m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    // test sequence
    initial begin
        n_errors      = 0;
        gap_left      = 0;
        hold_off      = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_DIM;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_LOAD;
        s_axis_tdata  = '0;
        cur_dim       = 14'd1;
        cur_alpha     = 32'h3F80_0000;
        cur_upper     = 1'b1;
        cur_reverse   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_phase(1, 32'h3F80_0000, 1'b1, 1'b0, 120);
        test_random_phase(8192, $urandom, 1'b0, 1'b1, 330);
        test_random_phase(16383, 32'hC0A0_0000, 1'b1, 1'b1, 300);
        test_random_phase(0, 32'h0000_0000, 1'b0, 1'b0, 60);
        test_random_phase(37, 32'h3E80_0000, 1'b0, 1'b0, 300);
        test_random_phase($urandom_range(2, 8192), rand_fp(), 1'b1, 1'b0, 300);
        drain();

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
